// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define SABS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define SABS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SABS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SABS_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== sv/sabs_pkg.sv =====
// ---------------------------------------------------------------------------
// sabs_pkg
// Sizes, codes and shared types of the sorted array bound search block.
// ---------------------------------------------------------------------------
package sabs_pkg;

    localparam int DEPTH         = 1024;
    localparam int ELEMENT_WIDTH = 32;

    localparam int MODE_W  = 3;
    localparam int SLOT_W  = 10;
    localparam int KEY_W   = 32;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 11;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int N_W   = $clog2(DEPTH + 1);
    localparam int CMP_W = (ELEMENT_WIDTH > KEY_W) ? ELEMENT_WIDTH : KEY_W;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_LOAD     = 3'd0;
    localparam mode_t MODE_FIRST_EQ = 3'd1;
    localparam mode_t MODE_LAST_EQ  = 3'd2;
    localparam mode_t MODE_FIRST_GE = 3'd3;
    localparam mode_t MODE_LAST_LE  = 3'd4;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_NCMP,
        S_DONE
    } state_t;

    typedef struct packed
    {
        logic wr_en;
        logic start;
        logic probe;
        logic read_nb;
        logic upd_lo;
        logic upd_end;
        logic set_hit;
        logic set_miss;
        logic res_load;
    } dp_cmd_t;

    typedef struct packed
    {
        logic is_load;
        logic is_query;
        logic range_ok;
        logic lt;
        logic cand;
        logic at_edge;
        logic nb_ok;
        logic nb_left;
        logic res_space;
    } dp_sts_t;

endpackage

// ===== sv/sabs_if.sv =====
// ---------------------------------------------------------------------------
// sabs_if
// Valid/ready channels for request items and response items.
// ---------------------------------------------------------------------------
interface sabs_req_if
    import sabs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    mode_t                   mode;
    logic [SLOT_W-1:0]       slot;
    logic signed [KEY_W-1:0] key_value;

    modport source (output valid, output mode, output slot, output key_value, input ready);
    modport sink   (input valid, input mode, input slot, input key_value, output ready);
endinterface

interface sabs_rsp_if
    import sabs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

// ===== sv/sabs_ram.sv =====
// ---------------------------------------------------------------------------
// sabs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module sabs_ram #(
    parameter int WORDS  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/sabs_datapath.sv =====
// ---------------------------------------------------------------------------
// sabs_datapath
// Element store, search bounds, comparator and response register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sabs_datapath
    import sabs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [COUNT_W-1:0]      cfg_wr_data,
    input  mode_t                   req_mode,
    input  logic [SLOT_W-1:0]       req_slot,
    input  logic signed [KEY_W-1:0] req_key,
    input  dp_cmd_t                 cmd,
    output dp_sts_t                 sts,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic                    rsp_found,
    output logic [POS_W-1:0]        rsp_position
);

    logic [COUNT_W-1:0]      count_reg;
    mode_t                   mode_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [N_W-1:0]          lo_reg;
    logic [N_W-1:0]          end_reg;
    logic [N_W-1:0]          n_reg;
    logic [IDX_W-1:0]        mid_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_pos_reg;
    logic                    rsp_valid_reg;
    logic                    rsp_found_reg;
    logic [POS_W-1:0]        rsp_pos_reg;

    logic [N_W-1:0]            n_clamp;
    logic [N_W-1:0]            span;
    logic [N_W-1:0]            mid_wide;
    logic [IDX_W-1:0]          mid_calc;
    logic                      wr_en;
    logic [IDX_W-1:0]          rd_addr;
    logic                      rd_en;
    logic [ELEMENT_WIDTH-1:0]  rd_data;
    logic signed [CMP_W-1:0]   elem_ext;
    logic signed [CMP_W-1:0]   key_ext;
    logic                      lt;
    logic                      eq;
    logic                      gt;
    logic                      nb_left;

    assign n_clamp  = (32'(count_reg) > DEPTH) ? N_W'(DEPTH) : N_W'(count_reg);
    assign span     = end_reg - lo_reg - N_W'(1);
    assign mid_wide = lo_reg + (span >> 1);
    assign mid_calc = IDX_W'(mid_wide);

    assign elem_ext = CMP_W'($signed(rd_data));
    assign key_ext  = CMP_W'(key_reg);
    assign lt       = elem_ext < key_ext;
    assign eq       = elem_ext == key_ext;
    assign gt       = elem_ext > key_ext;

    // first-style modes confirm against the left neighbour, last-style against the right
    assign nb_left = (mode_reg == MODE_FIRST_EQ) || (mode_reg == MODE_FIRST_GE);

    assign wr_en   = cmd.wr_en && (32'(req_slot) < DEPTH);
    assign rd_en   = cmd.probe || cmd.read_nb;
    assign rd_addr = cmd.probe ? mid_calc
                   : (nb_left ? mid_reg - IDX_W'(1) : mid_reg + IDX_W'(1));

    sabs_ram #(
        .WORDS  (DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (ELEMENT_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(req_slot)),
        .wr_data (ELEMENT_WIDTH'(req_key)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        sts.is_load   = req_mode == MODE_LOAD;
        sts.is_query  = (req_mode == MODE_FIRST_EQ) || (req_mode == MODE_LAST_EQ) ||
                        (req_mode == MODE_FIRST_GE) || (req_mode == MODE_LAST_LE);
        sts.range_ok  = lo_reg < end_reg;
        sts.lt        = lt;
        sts.nb_left   = nb_left;
        sts.at_edge   = nb_left ? (mid_reg == '0)
                                : ((N_W'(mid_reg) + N_W'(1)) == n_reg);
        sts.res_space = !rsp_valid_reg || rsp_ready;
        case (mode_reg)
            MODE_FIRST_EQ,
            MODE_LAST_EQ:
            begin
                sts.cand  = eq;
                sts.nb_ok = !eq;
            end
            MODE_FIRST_GE:
            begin
                sts.cand  = !lt;
                sts.nb_ok = lt;
            end
            MODE_LAST_LE:
            begin
                sts.cand  = !gt;
                sts.nb_ok = gt;
            end
            default:
            begin
                sts.cand  = 1'b0;
                sts.nb_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            lo_reg        <= '0;
            end_reg       <= '0;
            n_reg         <= '0;
            mid_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            if (cmd.start)
            begin
                lo_reg  <= '0;
                end_reg <= n_clamp;
                n_reg   <= n_clamp;
            end
            if (cmd.probe)
            begin
                mid_reg <= mid_calc;
            end
            if (cmd.upd_lo)
            begin
                lo_reg <= N_W'(mid_reg) + N_W'(1);
            end
            if (cmd.upd_end)
            begin
                end_reg <= N_W'(mid_reg);
            end
            if (cmd.res_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg <= req_mode;
            key_reg  <= req_key;
        end
        if (cmd.set_hit)
        begin
            hit_reg     <= 1'b1;
            hit_pos_reg <= mid_reg;
        end
        if (cmd.set_miss)
        begin
            hit_reg     <= 1'b0;
            hit_pos_reg <= '0;
        end
        if (cmd.res_load)
        begin
            rsp_found_reg <= hit_reg;
            rsp_pos_reg   <= POS_W'(hit_pos_reg);
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign rsp_found    = rsp_found_reg;
    assign rsp_position = rsp_pos_reg;

    `SABS_ASSERT(a_probe_in_range, clk, rst_n, cmd.probe |-> (lo_reg < end_reg), "probe on empty range")
    `SABS_ASSERT(a_mid_below_n, clk, rst_n, cmd.probe |=> (N_W'(mid_reg) < n_reg), "probe index beyond count")
    `SABS_ASSERT(a_bounds_ordered, clk, rst_n, (lo_reg <= end_reg) && (end_reg <= n_reg), "search bounds out of order")
    `SABS_NEVER(a_nb_inside, clk, rst_n, cmd.read_nb && sts.at_edge, "neighbour read past array edge")
    `SABS_NEVER(a_rsp_overrun, clk, rst_n, cmd.res_load && !sts.res_space, "response register overwritten")

endmodule

// ===== sv/sabs_ctrl.sv =====
// ---------------------------------------------------------------------------
// sabs_ctrl
// Sequencer for load items and the probe loop of the bound search.
// ---------------------------------------------------------------------------
module sabs_ctrl
    import sabs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (sts.is_load)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else if (sts.is_query)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (sts.range_ok)
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_CMP:
            begin
                if (sts.cand)
                begin
                    if (sts.at_edge)
                    begin
                        cmd.set_hit = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.read_nb = 1'b1;
                        state_next  = S_NCMP;
                    end
                end
                else
                begin
                    // element below key: drop the left half, else the right half
                    cmd.upd_lo  = sts.lt;
                    cmd.upd_end = !sts.lt;
                    state_next  = S_PROBE;
                end
            end
            S_NCMP:
            begin
                if (sts.nb_ok)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.upd_end = sts.nb_left;
                    cmd.upd_lo  = !sts.nb_left;
                    state_next  = S_PROBE;
                end
            end
            S_DONE:
            begin
                // hold until the response register is free
                if (sts.res_space)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sorted_array_bound_search_top.sv =====
// ---------------------------------------------------------------------------
// sorted_array_bound_search_top
// Binary search over a loaded, sorted array of signed elements.
// ---------------------------------------------------------------------------
// A load item takes one cycle and writes one element into a synchronous RAM.
// A query item is worked on alone: one cycle to accept, then per probe two
// cycles (compute the middle index and read it, then compare), plus one more
// when the neighbour must be read to confirm a candidate, one more to find the
// range empty when nothing matches, and one cycle to move the answer into the
// response register, held there for as long as that register stays full. With
// n elements a query takes from 3 up to 3 + 3*ceil(log2(n+1)) cycles (36 for a
// full array), set by the one RAM read port shared by the middle and neighbour
// reads. The response register lets the next item be accepted while a
// response still waits.
module sorted_array_bound_search_top
    import sabs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    sabs_req_if.sink           req,
    sabs_rsp_if.source         rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    sabs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sabs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req_mode     (req.mode),
        .req_slot     (req.slot),
        .req_key      (req.key_value),
        .cmd          (cmd),
        .sts          (sts),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .rsp_found    (rsp.found),
        .rsp_position (rsp.position)
    );

endmodule
